[design/mmskc_pkg.sv]
package mmskc_pkg;

    // Entry kinds
    localparam logic [2:0] KIND_SOURCE   = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_END      = 3'd2;
    localparam logic [2:0] KIND_SORT_PAD = 3'd3;
    localparam logic [2:0] KIND_DIST_PAD = 3'd4;

    localparam int TDATA_W  = 128;
    localparam int TUSER_W  = 8;
    localparam int MDATA_W  = 8;

    typedef enum logic [2:0] {
        MODE_JOIN      = 3'd0,
        MODE_PAIRWISE  = 3'd1,
        MODE_END_FIRST = 3'd2,
        MODE_JOIN_ATTR = 3'd3,
        MODE_INDEX     = 3'd4,
        MODE_ALIGN     = 3'd5,
        MODE_PAD_LAST  = 3'd6,
        MODE_DEST      = 3'd7
    } t_mode;

    typedef struct packed {
        logic [2:0]  type_a;
        logic        eq_a;
        logic [31:0] join_a;
        logic [31:0] key_a;
        logic [2:0]  type_b;
        logic        eq_b;
        logic [31:0] join_b;
        logic [31:0] key_b;
        logic        last_element;
    } t_item;

    // Per-item decision terms handed from the compare logic to the result stage
    typedef struct packed {
        logic lt;        // answer for every mode but join-then-attrs
        logic head_dec;  // run head settles the answer (padding or join attribute)
        logic head_ans;
        logic key_ne;    // attribute pair differs
        logic key_lt;
    } t_verdict;

    // Boundary precedence: lower orders first
    function automatic logic [1:0] precedence(input logic [2:0] kind, input logic excl);
        logic [1:0] p;
        begin
            p = 2'd0;
            if (kind == KIND_SOURCE) begin
                p = 2'd2;
            end else if (kind == KIND_START) begin
                p = excl ? 2'd3 : 2'd1;
            end else if (kind == KIND_END) begin
                p = excl ? 2'd1 : 2'd3;
            end
            return p;
        end
    endfunction

endpackage

[design/mmskc_in_stage.sv]
module mmskc_in_stage
    import mmskc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TDATA_W-1:0] i_data,
    input  logic [TUSER_W-1:0] i_user,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_advance,
    output t_item              o_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_vld || i_advance;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_item.type_a       = i_user[2:0];
        n_item.eq_a         = i_user[3];
        n_item.join_a       = i_data[31:0];
        n_item.key_a        = i_data[63:32];
        n_item.type_b       = i_user[6:4];
        n_item.eq_b         = i_user[7];
        n_item.join_b       = i_data[95:64];
        n_item.key_b        = i_data[127:96];
        n_item.last_element = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

[design/mmskc_order.sv]
module mmskc_order
    import mmskc_pkg::*;
(
    input  t_mode    i_mode,
    input  t_item    i_item,
    output t_verdict o_verdict
);

    logic pad_a, pad_b, spad_a, spad_b;
    logic join_ne, join_lt, key_ne, key_lt;
    logic tgt_a, tgt_b, end_a, end_b;
    logic lt;

    assign spad_a  = (i_item.type_a == KIND_SORT_PAD);
    assign spad_b  = (i_item.type_b == KIND_SORT_PAD);
    assign join_ne = (i_item.join_a != i_item.join_b);
    assign join_lt = ($signed(i_item.join_a) < $signed(i_item.join_b));
    assign key_ne  = (i_item.key_a != i_item.key_b);
    assign key_lt  = ($signed(i_item.key_a) < $signed(i_item.key_b));
    assign tgt_a   = (i_item.type_a == KIND_START) || (i_item.type_a == KIND_END);
    assign tgt_b   = (i_item.type_b == KIND_START) || (i_item.type_b == KIND_END);
    assign end_a   = (i_item.type_a == KIND_END);
    assign end_b   = (i_item.type_b == KIND_END);

    // padding-last mode also drops distribution padding to the back
    assign pad_a = spad_a || ((i_mode == MODE_PAD_LAST) && (i_item.type_a == KIND_DIST_PAD));
    assign pad_b = spad_b || ((i_mode == MODE_PAD_LAST) && (i_item.type_b == KIND_DIST_PAD));

    always_comb begin
        lt = key_lt;
        if (pad_a != pad_b) begin
            lt = pad_b;
        end else begin
            unique case (i_mode)
                MODE_JOIN: begin
                    if (join_ne) begin
                        lt = join_lt;
                    end else begin
                        lt = precedence(i_item.type_a, i_item.eq_a)
                           < precedence(i_item.type_b, i_item.eq_b);
                    end
                end
                MODE_PAIRWISE: begin
                    if (tgt_a != tgt_b) begin
                        lt = tgt_a;
                    end else if (key_ne) begin
                        lt = key_lt;
                    end else begin
                        lt = (i_item.type_a == KIND_START) && end_b;
                    end
                end
                MODE_END_FIRST: begin
                    lt = (end_a != end_b) ? end_a : key_lt;
                end
                default: begin
                    lt = key_lt;
                end
            endcase
        end
    end

    assign o_verdict.lt       = lt;
    assign o_verdict.head_dec = (spad_a != spad_b) || join_ne;
    assign o_verdict.head_ans = (spad_a != spad_b) ? spad_b : join_lt;
    assign o_verdict.key_ne   = key_ne;
    assign o_verdict.key_lt   = key_lt;

endmodule

[design/mmskc_out_stage.sv]
module mmskc_out_stage
    import mmskc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mode    i_mode,
    input  logic     i_valid,
    input  logic     i_last,
    input  t_verdict i_verdict,
    output logic     o_advance,
    output logic     o_valid,
    input  logic     i_ready,
    output logic     o_lt
);

    logic r_started, r_decided, r_answer;
    logic n_started, n_decided, n_answer;
    logic r_out_vld, r_out_lt;
    logic n_out_vld, n_out_lt;
    logic dec0, ans0, dec1, ans1;
    logic slot_free;

    assign slot_free = !r_out_vld || i_ready;
    assign o_advance = i_valid && slot_free;
    assign o_valid   = r_out_vld;
    assign o_lt      = r_out_lt;

    always_comb begin
        // head decision only on the first beat of a run
        dec0 = r_decided;
        ans0 = r_answer;
        if (!r_started && !r_decided && i_verdict.head_dec) begin
            dec0 = 1'b1;
            ans0 = i_verdict.head_ans;
        end
        dec1 = dec0;
        ans1 = ans0;
        if (!dec0 && i_verdict.key_ne) begin
            dec1 = 1'b1;
            ans1 = i_verdict.key_lt;
        end

        n_started = r_started;
        n_decided = r_decided;
        n_answer  = r_answer;
        n_out_vld = r_out_vld && !i_ready;
        n_out_lt  = r_out_lt;
        if (o_advance) begin
            if (i_mode == MODE_JOIN_ATTR) begin
                if (i_last) begin
                    n_out_vld = 1'b1;
                    n_out_lt  = ans1;
                    n_started = 1'b0;
                    n_decided = 1'b0;
                    n_answer  = 1'b0;
                end else begin
                    n_started = 1'b1;
                    n_decided = dec1;
                    n_answer  = ans1;
                end
            end else begin
                n_out_vld = 1'b1;
                n_out_lt  = i_verdict.lt;
                n_started = 1'b0;
                n_decided = 1'b0;
                n_answer  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_decided <= 1'b0;
            r_answer  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_started <= n_started;
            r_decided <= n_decided;
            r_answer  <= n_answer;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_lt <= n_out_lt;
    end

endmodule

[design/multi_mode_sort_key_comparator.sv]
// Sort-key comparator for a merge-sort engine: tells whether entry A orders
// strictly before entry B under one of eight modes set by compare_mode.
// Slave channel (s_axis_*): one beat per comparison. tdata carries join_a,
// key_a, join_b, key_b; tuser carries the kinds and boundary flags; tlast
// marks the final attribute pair of a run in join-then-attrs mode.
// Master channel (m_axis_*): one beat per answer, a_less_than_b in bit 0.
// Every beat yields an answer, except in join-then-attrs mode where only the
// beat with tlast set yields one (for the whole run).
// Path: a beat is taken into the input register; the compare logic then feeds
// its answer into the output register.
// Throughput: one beat per cycle while the output is not stalled, set by the single compare stage.
// Stall: while the receiver holds m_axis_tready low the output register holds
// its beat, the input register fills, and s_axis_tready drops after that.
// Reset (i_rst_n low, synchronous): both registers empty, run state cleared,
// compare_mode back to join ordering. Write compare_mode via i_cfg_we while
// no beat is in flight.
module multi_mode_sort_key_comparator
    import mmskc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_wdata,   // compare_mode
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] join_a, [63:32] key_a, [95:64] join_b, [127:96] key_b
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // [2:0] type_a, [3] eq_a, [6:4] type_b, [7] eq_b
    input  logic [TUSER_W-1:0] s_axis_tuser,
    input  logic               s_axis_tlast,  // last_element
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] a_less_than_b, [7:1] zero
    output logic [MDATA_W-1:0] m_axis_tdata
);

    t_mode    r_mode;
    t_item    item;
    t_verdict verdict;
    logic     item_vld;
    logic     advance;
    logic     lt;

    // mode register: no read-back; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_JOIN;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    // capture the beat
    mmskc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .o_valid   (item_vld),
        .i_advance (advance),
        .o_item    (item)
    );

    // ordering decision, purely combinational
    mmskc_order u_order (
        .i_mode    (r_mode),
        .i_item    (item),
        .o_verdict (verdict)
    );

    // run state and result register
    mmskc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_valid   (item_vld),
        .i_last    (item.last_element),
        .i_verdict (verdict),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_lt      (lt)
    );

    assign m_axis_tdata = {{(MDATA_W-1){1'b0}}, lt};

endmodule
